// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and types for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int ADDR_W        = $clog2(TABLE_SIZE);
    localparam int BYTE_W        = 8;
    localparam int MAX_KEY_BYTES = 256;
    localparam int KCNT_W        = $clog2(MAX_KEY_BYTES + 1);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    // write port of a table RAM
    typedef struct packed {
        logic  en;
        t_addr addr;
        t_byte data;
    } t_ram_wr;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_FILL = 11'b000_0000_0010,
        ST_K_RD = 11'b000_0000_0100,
        ST_K_J  = 11'b000_0000_1000,
        ST_K_WJ = 11'b000_0001_0000,
        ST_K_WI = 11'b000_0010_0000,
        ST_G_RJ = 11'b000_0100_0000,
        ST_G_WJ = 11'b000_1000_0000,
        ST_G_WI = 11'b001_0000_0000,
        ST_G_KS = 11'b010_0000_0000,
        ST_OUT  = 11'b100_0000_0000
    } t_state;

endpackage

// ===== rtl/rc4_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 stream cipher: key byte collection, key schedule and keystream
// generation, all sequenced over one permutation RAM.
//
//   channel | valid    | ready    | payload
//   --------+----------+----------+-------------------------------------------
//   input   | i_valid  | o_ready  | i_cmd, i_byte_in, i_key_last
//   output  | o_valid  | i_ready  | o_data_out, o_keystream_out, o_unkeyed
//
// Key byte: taken in the idle state. Final key byte: identity fill, then the
// key schedule steps (read, write S[j], write S[i]). Keyed data byte: the
// dependent read/swap/read chain on the one-read, one-write permutation RAM.
// Unkeyed data byte: straight to the output state.
// Reset clears control state only; tables are not cleared, each schedule
// refills the permutation. A stalled output holds the sequencer in its last
// state; key bytes are still taken while a result waits.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top
    import rc4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_byte_in,
    input  logic        i_key_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_out,
    output logic [7:0]  o_keystream_out,
    output logic        o_unkeyed
);

    t_state              r_state, n_state;
    t_addr               r_i, n_i;
    t_addr               r_j, n_j;
    t_addr               r_n, n_n;
    t_addr               r_kidx, n_kidx;
    t_addr               r_t, n_t;
    logic [KCNT_W-1:0]   r_klen, n_klen;
    logic [KCNT_W-1:0]   r_key_count, n_key_count;
    logic                r_keyed, n_keyed;
    t_byte               r_si, n_si;
    t_byte               r_sj, n_sj;
    t_byte               r_byte, n_byte;
    t_byte               r_res_ks, n_res_ks;
    logic                r_res_unk, n_res_unk;
    logic                r_out_valid, n_out_valid;
    t_byte               r_out_data, n_out_data;
    t_byte               r_out_ks, n_out_ks;
    logic                r_out_unk, n_out_unk;

    t_ram_wr             s_wr, k_wr;
    t_addr               s_raddr, k_raddr;
    t_byte               s_rdata, k_rdata;

    logic [KCNT_W-1:0]   cnt_inc;
    logic [KCNT_W-1:0]   kidx_inc;
    t_addr               kidx_next;
    t_addr               j_sum;

    rc4_ram u_perm (
        .i_clk   (i_clk),
        .i_wr    (s_wr),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    rc4_ram u_key (
        .i_clk   (i_clk),
        .i_wr    (k_wr),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    assign cnt_inc   = r_key_count + KCNT_W'(1);
    assign kidx_inc  = {1'b0, r_kidx} + KCNT_W'(1);
    assign kidx_next = (kidx_inc == r_klen) ? '0 : kidx_inc[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_t         = r_t;
        n_klen      = r_klen;
        n_key_count = r_key_count;
        n_keyed     = r_keyed;
        n_si        = r_si;
        n_sj        = r_sj;
        n_byte      = r_byte;
        n_res_ks    = r_res_ks;
        n_res_unk   = r_res_unk;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_ks    = r_out_ks;
        n_out_unk   = r_out_unk;
        s_wr        = '0;
        k_wr        = '0;
        s_raddr     = r_n;
        k_raddr     = r_kidx;
        j_sum       = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_KEY) begin
                        if (r_key_count < KCNT_W'(MAX_KEY_BYTES)) begin
                            k_wr.en     = 1'b1;
                            k_wr.addr   = r_key_count[ADDR_W-1:0];
                            k_wr.data   = i_byte_in;
                            n_key_count = cnt_inc;
                        end
                        if (i_key_last) begin
                            n_klen      = (n_key_count == '0) ? KCNT_W'(1) : n_key_count;
                            n_key_count = '0;
                            n_n         = '0;
                            n_state     = ST_FILL;
                        end
                    end else begin
                        n_byte = i_byte_in;
                        if (!r_keyed) begin
                            n_res_ks  = '0;
                            n_res_unk = 1'b1;
                            n_state   = ST_OUT;
                        end else begin
                            n_res_unk = 1'b0;
                            n_i       = r_i + t_addr'(1);
                            s_raddr   = r_i + t_addr'(1);
                            n_state   = ST_G_RJ;
                        end
                    end
                end
            end
            ST_FILL: begin
                s_wr.en   = 1'b1;
                s_wr.addr = r_n;
                s_wr.data = r_n;
                n_n       = r_n + t_addr'(1);
                if (r_n == t_addr'(TABLE_SIZE - 1)) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = ST_K_RD;
                end
            end
            ST_K_RD: begin
                s_raddr = r_n;
                k_raddr = r_kidx;
                n_state = ST_K_J;
            end
            ST_K_J: begin
                j_sum   = r_j + s_rdata + k_rdata;
                n_j     = j_sum;
                s_raddr = j_sum;
                n_si    = s_rdata;
                n_state = ST_K_WJ;
            end
            ST_K_WJ: begin
                n_sj      = s_rdata;
                s_wr.en   = 1'b1;
                s_wr.addr = r_j;
                s_wr.data = r_si;
                n_state   = ST_K_WI;
            end
            ST_K_WI: begin
                s_wr.en   = 1'b1;
                s_wr.addr = r_n;
                s_wr.data = r_sj;
                n_kidx    = kidx_next;
                n_n       = r_n + t_addr'(1);
                // overlap the next step's reads with this write
                s_raddr   = r_n + t_addr'(1);
                k_raddr   = kidx_next;
                if (r_n == t_addr'(TABLE_SIZE - 1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_K_J;
                end
            end
            ST_G_RJ: begin
                n_si    = s_rdata;
                j_sum   = r_j + s_rdata;
                n_j     = j_sum;
                s_raddr = j_sum;
                n_state = ST_G_WJ;
            end
            ST_G_WJ: begin
                n_sj      = s_rdata;
                s_wr.en   = 1'b1;
                s_wr.addr = r_j;
                s_wr.data = r_si;
                n_state   = ST_G_WI;
            end
            ST_G_WI: begin
                s_wr.en   = 1'b1;
                s_wr.addr = r_i;
                s_wr.data = r_sj;
                n_t       = r_si + r_sj;
                s_raddr   = r_si + r_sj;
                n_state   = ST_G_KS;
            end
            ST_G_KS: begin
                // read of S[i] overlapped its own write: forward the new value
                n_res_ks = (r_t == r_i) ? r_sj : s_rdata;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_byte ^ r_res_ks;
                    n_out_ks    = r_res_ks;
                    n_out_unk   = r_res_unk;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_kidx      <= '0;
            r_klen      <= KCNT_W'(1);
            r_key_count <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
            r_klen      <= n_klen;
            r_key_count <= n_key_count;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_byte     <= n_byte;
        r_res_ks   <= n_res_ks;
        r_res_unk  <= n_res_unk;
        r_out_data <= n_out_data;
        r_out_ks   <= n_out_ks;
        r_out_unk  <= n_out_unk;
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_data_out      = r_out_data;
    assign o_keystream_out = r_out_ks;
    assign o_unkeyed       = r_out_unk;

endmodule

// ===== rtl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// 256 x 8 table RAM, one write and one read port, registered read data
// (read during write to the same address returns the old contents).
// ----------------------------------------------------------------------------
module rc4_ram
    import rc4_pkg::*;
(
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_addr   i_raddr,
    output t_byte   o_rdata
);

    t_byte r_mem [TABLE_SIZE];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rc4_chk.sv =====
// ----------------------------------------------------------------------------
// rc4_chk
// Port-level checks for the RC4 stream cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module rc4_chk
    import rc4_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_cmd,
    input logic        i_key_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_data_out,
    input logic [7:0]  o_keystream_out,
    input logic        o_unkeyed
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_valid && o_ready;
    assign out_stall = o_valid && !i_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> o_valid && $stable(o_data_out) && $stable(o_keystream_out)
                      && $stable(o_unkeyed))
        else $error("output changed while stalled");

    a_unkeyed_ks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unkeyed |-> o_keystream_out == '0)
        else $error("unkeyed result with nonzero keystream");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_cmd == CMD_DATA) |=> !o_ready)
        else $error("ready right after a data transfer");

    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_cmd == CMD_KEY) && i_key_last |=> !o_ready)
        else $error("ready right after final key byte");

    a_key_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_cmd == CMD_KEY) && !i_key_last |=> o_ready)
        else $error("key byte not taken in one cycle");

endmodule

bind rc4_stream_cipher_top rc4_chk u_rc4_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_cmd           (i_cmd),
    .i_key_last      (i_key_last),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_data_out      (o_data_out),
    .o_keystream_out (o_keystream_out),
    .o_unkeyed       (o_unkeyed)
);

// ===== bench/rc4_stream_cipher_top_tb.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_tb
// Self-checking bench for the RC4 stream cipher. A short directed table
// covers unkeyed pass-through, one-byte keys at both byte extremes, key loads
// interleaved with data, and the ignored key_last flag on data bytes. Random
// sessions follow: key loads of random length, including loads that reach
// and pass the key store limit, with data bytes mixed in, then data bursts.
// Each transfer is predicted by a local RC4 model and results are compared
// in order. Both handshakes idle at random, with stretches of no idling.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top_tb
    import rc4_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS = 1500;
    localparam int END_DRAIN = 1500;   // covers a full key schedule
    localparam int N_ROWS    = 24;

    typedef struct packed {
        t_byte data_out;
        t_byte keystream;
        logic  unkeyed;
    } cipher_result_t;

    typedef struct packed {
        logic           cmd;
        t_byte          din;
        logic           last;
        logic           typed;
        cipher_result_t want;
    } stim_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_cmd;
    logic [7:0] i_byte_in;
    logic       i_key_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_out;
    logic [7:0] o_keystream_out;
    logic       o_unkeyed;

    // local cipher state
    t_byte       perm_model [TABLE_SIZE];
    t_byte       key_model  [TABLE_SIZE];
    int unsigned key_fill;
    t_byte       gen_i;
    t_byte       gen_j;
    bit          keyed;

    cipher_result_t pending_results_q [$];
    int             error_count;
    int             sent_items;
    bit             src_burst;
    bit             sink_burst;

    // unkeyed rows are typed in; the rest go through the local model
    stim_row_t directed_rows [N_ROWS] = '{
        '{CMD_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, 1'b1}},
        '{CMD_DATA, 8'hFF, 1'b1, 1'b1, '{8'hFF, 8'h00, 1'b1}},
        '{CMD_DATA, 8'h5A, 1'b0, 1'b1, '{8'h5A, 8'h00, 1'b1}},
        '{CMD_KEY,  8'h00, 1'b1, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'hFF, 1'b1, 1'b0, '0},
        '{CMD_DATA, 8'hA5, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'hFF, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'h01, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'h80, 1'b1, 1'b0, '0},
        '{CMD_DATA, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'h4B, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'h65, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'h79, 1'b1, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_KEY,  8'hFF, 1'b1, 1'b0, '0},
        '{CMD_DATA, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_DATA, 8'h00, 1'b1, 1'b0, '0}
    };

    rc4_stream_cipher_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_byte_in       (i_byte_in),
        .i_key_last      (i_key_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data_out      (o_data_out),
        .o_keystream_out (o_keystream_out),
        .o_unkeyed       (o_unkeyed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // key schedule over a fresh identity table; key length is the fill count
    function automatic void schedule_key();
        int unsigned len;
        int          n;
        t_byte       acc;
        t_byte       tmp;
        len = (key_fill == 0) ? 1 : key_fill;
        for (n = 0; n < TABLE_SIZE; n++)
            perm_model[n] = t_byte'(n);
        acc = '0;
        for (n = 0; n < TABLE_SIZE; n++) begin
            acc = acc + perm_model[n] + key_model[n % len];
            tmp = perm_model[acc];
            perm_model[acc] = perm_model[n];
            perm_model[n] = tmp;
        end
        gen_i    = '0;
        gen_j    = '0;
        key_fill = 0;
        keyed    = 1'b1;
    endfunction

    // returns 1 when the transfer produces a result
    function automatic bit predict_cipher(input logic cmd, input t_byte din,
                                          input logic last, output cipher_result_t res);
        t_byte tmp;
        t_byte ks;
        res = '0;
        if (cmd == CMD_KEY) begin
            // bytes past the store limit are dropped, key_last still schedules
            if (key_fill < MAX_KEY_BYTES) begin
                key_model[key_fill] = din;
                key_fill++;
            end
            if (last)
                schedule_key();
            return 1'b0;
        end
        if (!keyed) begin
            res.data_out  = din;
            res.keystream = '0;
            res.unkeyed   = 1'b1;
            return 1'b1;
        end
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm_model[gen_i];
        tmp = perm_model[gen_i];
        perm_model[gen_i] = perm_model[gen_j];
        perm_model[gen_j] = tmp;
        ks = perm_model[t_byte'(perm_model[gen_i] + perm_model[gen_j])];
        res.data_out  = ks ^ din;
        res.keystream = ks;
        res.unkeyed   = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic cmd, input t_byte din, input logic last,
                             input logic typed, input cipher_result_t want);
        int             gap;
        cipher_result_t res;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_byte_in  <= din;
        i_key_last <= last;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
        if (predict_cipher(cmd, din, last, res))
            pending_results_q.push_back(typed ? want : res);
    endtask

    task automatic send_data();
        send_byte(CMD_DATA, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, '0);
    endtask

    // one key load with stray data bytes mixed in, then a data burst
    task automatic run_session(input int key_len);
        int k;
        int n_data;
        src_burst = ($urandom_range(0, 4) == 0);
        for (k = 0; k < key_len; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_data();
            send_byte(CMD_KEY, t_byte'($urandom_range(0, 255)), k == key_len - 1,
                      1'b0, '0);
        end
        n_data = $urandom_range(0, 40);
        repeat (n_data) send_data();
    endtask

    function automatic int draw_key_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 16);
        else if (r < 95)
            return $urandom_range(17, 255);
        return $urandom_range(256, 300);
    endfunction

    // result side
    initial begin
        int gap;
        forever begin
            if ($urandom_range(0, 31) == 0)
                sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        cipher_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results_q.size() == 0) begin
                $error("unexpected result transfer: data_out=%h keystream_out=%h",
                       o_data_out, o_keystream_out);
                error_count++;
            end else begin
                want = pending_results_q.pop_front();
                if (o_data_out !== want.data_out) begin
                    $error("data_out mismatch: expected %h, got %h",
                           want.data_out, o_data_out);
                    error_count++;
                end
                if (o_keystream_out !== want.keystream) begin
                    $error("keystream_out mismatch: expected %h, got %h",
                           want.keystream, o_keystream_out);
                    error_count++;
                end
                if (o_unkeyed !== want.unkeyed) begin
                    $error("unkeyed mismatch: expected %b, got %b",
                           want.unkeyed, o_unkeyed);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int r;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_cmd      <= CMD_KEY;
        i_byte_in  <= '0;
        i_key_last <= 1'b0;
        error_count = 0;
        sent_items  = 0;
        src_burst   = 1'b0;
        for (r = 0; r < TABLE_SIZE; r++)
            perm_model[r] = t_byte'(r);
        key_fill = 0;
        gen_i    = '0;
        gen_j    = '0;
        keyed    = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++)
            send_byte(directed_rows[r].cmd, directed_rows[r].din, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);

        // a full key store, then one that overflows it
        run_session(MAX_KEY_BYTES);
        run_session($urandom_range(MAX_KEY_BYTES + 1, 300));
        while (sent_items < NUM_ITEMS)
            run_session(draw_key_len());
        i_valid <= 1'b0;

        while (pending_results_q.size() != 0)
            @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
